[rtl/ilis_pkg.sv]
`default_nettype none

package ilis_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // common width for position, count and cell index compares
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_ERASE  = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_DUMP   = 2'd3
    } req_type_t;

    typedef struct packed {
        req_type_t                 req_type;
        logic [POS_W-1:0]          position;
        logic signed [DATA_W-1:0]  value_in;
    } req_item_t;

    typedef struct packed {
        logic                      ok;
        logic                      is_item;
        logic signed [DATA_W-1:0]  value_out;
        logic                      last;
    } rsp_item_t;

    // what a cell loads this cycle
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LEFT,
        CELL_RIGHT,
        CELL_NEW,
        CELL_HEAD
    } cell_sel_t;

    typedef struct packed {
        cell_sel_t sel;
        logic      cmp_en;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DUMP
    } state_t;

endpackage

`default_nettype wire

[rtl/indexed_list_insert_erase_search.sv]
`default_nettype none

// ordered list of up to 32 signed words held in a chain of cells, one entry per cell,
// entry 0 in cell 0. insert and erase shift every later cell by one place at the edge
// that takes the request, and their response is registered at that edge; search
// registers a compare flag in each cell below count and the response is then loaded
// from those flags in the search state; dump streams one entry per cycle from cell 0
// while the receiver takes them, and the chain rotates left by one per entry, so after
// count entries the list is back in place (one response on an empty list). one request
// is in flight at a time: req_ready is high only while the control is idle and the
// response register is empty or being taken, so the rate is set by this sequencer and,
// for dump, by the rotation through cell 0. insert fails at a position beyond count or
// on a full list, erase fails at a position at or beyond count
module indexed_list_insert_erase_search (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output      logic                req_ready,
    input  wire ilis_pkg::req_item_t req,
    output      logic                rsp_valid,
    input  wire logic                rsp_ready,
    output      ilis_pkg::rsp_item_t rsp
);
    import ilis_pkg::*;

    // control state
    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  dump_idx_reg;
    logic [CNT_W-1:0]  dump_idx_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_item_t         rsp_reg;
    rsp_item_t         rsp_next;

    // handshake and decode
    logic              out_free;
    logic              accept;
    logic              rsp_load;
    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  cnt_x;
    logic              ins_ok;
    logic              era_ok;
    logic              dump_last;
    logic              list_empty;

    // chain operations for this cycle
    logic              do_insert;
    logic              do_erase;
    logic              do_search;
    logic              do_rotate;

    // the chain
    cell_ctrl_t                cell_ctrl  [CAPACITY];
    logic signed [DATA_W-1:0]  cell_value [CAPACITY];
    logic [CAPACITY-1:0]       cell_match;

    assign out_free   = !rsp_valid_reg || rsp_ready;
    assign req_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept     = req_valid && req_ready;

    assign pos_x      = CMP_W'(req.position);
    assign cnt_x      = CMP_W'(count_reg);
    assign ins_ok     = (pos_x <= cnt_x) && (cnt_x < CMP_W'(CAPACITY));
    assign era_ok     = pos_x < cnt_x;
    assign list_empty = (count_reg == '0);
    assign dump_last  = (CNT_W'(dump_idx_reg + 1'b1) == count_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.req_type == REQ_SEARCH))
                begin
                    state_next = ST_SEARCH;
                end
                else if (accept && (req.req_type == REQ_DUMP) && !list_empty)
                begin
                    state_next = ST_DUMP;
                end
            end
            ST_SEARCH:
            begin
                // response register is empty here: it was free at accept
                state_next = ST_IDLE;
            end
            ST_DUMP:
            begin
                if (out_free && dump_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        do_insert     = 1'b0;
        do_erase      = 1'b0;
        do_search     = 1'b0;
        do_rotate     = 1'b0;
        rsp_load      = 1'b0;
        rsp_next      = '0;
        rsp_next.last = 1'b1;
        count_next    = count_reg;
        dump_idx_next = dump_idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                dump_idx_next = '0;
                if (accept)
                begin
                    unique case (req.req_type)
                        REQ_INSERT:
                        begin
                            do_insert   = ins_ok;
                            rsp_load    = 1'b1;
                            rsp_next.ok = ins_ok;
                            if (ins_ok)
                            begin
                                count_next = CNT_W'(count_reg + 1'b1);
                            end
                        end
                        REQ_ERASE:
                        begin
                            do_erase    = era_ok;
                            rsp_load    = 1'b1;
                            rsp_next.ok = era_ok;
                            if (era_ok)
                            begin
                                count_next = CNT_W'(count_reg - 1'b1);
                            end
                        end
                        REQ_SEARCH:
                        begin
                            do_search = 1'b1;
                        end
                        REQ_DUMP:
                        begin
                            // empty list gives one marker response
                            if (list_empty)
                            begin
                                rsp_load    = 1'b1;
                                rsp_next.ok = 1'b1;
                            end
                        end
                        default:
                        begin
                            rsp_load = 1'b0;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                rsp_load    = 1'b1;
                rsp_next.ok = |cell_match;
            end
            ST_DUMP:
            begin
                if (out_free)
                begin
                    do_rotate          = 1'b1;
                    rsp_load           = 1'b1;
                    rsp_next.ok        = 1'b1;
                    rsp_next.is_item   = 1'b1;
                    rsp_next.value_out = cell_value[0];
                    rsp_next.last      = dump_last;
                    dump_idx_next      = CNT_W'(dump_idx_reg + 1'b1);
                end
            end
            default:
            begin
                rsp_load = 1'b0;
            end
        endcase
    end

    assign rsp_valid_next = rsp_load || (rsp_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_idx_reg  <= dump_idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // response payload, no reset
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // cell chain: per-cell select from its place against position and count
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [CMP_W-1:0] IDX = CMP_W'(i);

        logic signed [DATA_W-1:0] left_value;
        logic signed [DATA_W-1:0] right_value;

        // unused ends of the chain see the new value or the head
        if (i == 0)
        begin : g_first
            assign left_value = req.value_in;
        end
        else
        begin : g_inner_l
            assign left_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_value = cell_value[0];
        end
        else
        begin : g_inner_r
            assign right_value = cell_value[i+1];
        end

        always_comb
        begin
            cell_ctrl[i].sel    = CELL_HOLD;
            cell_ctrl[i].cmp_en = do_search && (IDX < cnt_x);
            priority if (do_insert && (IDX > pos_x))
            begin
                cell_ctrl[i].sel = CELL_LEFT;
            end
            else if (do_insert && (IDX == pos_x))
            begin
                cell_ctrl[i].sel = CELL_NEW;
            end
            else if (do_erase && (IDX >= pos_x))
            begin
                cell_ctrl[i].sel = CELL_RIGHT;
            end
            else if (do_rotate && (CMP_W'(IDX + 1'b1) == cnt_x))
            begin
                cell_ctrl[i].sel = CELL_HEAD;
            end
            else if (do_rotate && (CMP_W'(IDX + 1'b1) < cnt_x))
            begin
                cell_ctrl[i].sel = CELL_RIGHT;
            end
            else
            begin
                cell_ctrl[i].sel = CELL_HOLD;
            end
        end

        ilis_cell u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl[i]),
            .new_value   (req.value_in),
            .left_value  (left_value),
            .right_value (right_value),
            .head_value  (cell_value[0]),
            .search_key  (req.value_in),
            .value       (cell_value[i]),
            .match       (cell_match[i])
        );
    end

`ifndef SYNTHESIS
    a_count_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list count above capacity");

    a_search_rsp_free : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> !rsp_valid_reg)
        else $error("search result would overwrite a pending response");

    a_dump_idx_range : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> (dump_idx_reg < count_reg))
        else $error("dump index beyond list count");

    a_full_insert_keeps : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.req_type == REQ_INSERT) && (count_reg == CNT_W'(CAPACITY)))
        |=> (count_reg == $past(count_reg)))
        else $error("insert into a full list changed the count");
`endif

endmodule

`default_nettype wire

[rtl/ilis_cell.sv]
`default_nettype none

module ilis_cell (
    input  wire logic                               clk,
    input  wire ilis_pkg::cell_ctrl_t               ctrl,
    input  wire logic signed [ilis_pkg::DATA_W-1:0] new_value,
    input  wire logic signed [ilis_pkg::DATA_W-1:0] left_value,
    input  wire logic signed [ilis_pkg::DATA_W-1:0] right_value,
    input  wire logic signed [ilis_pkg::DATA_W-1:0] head_value,
    input  wire logic signed [ilis_pkg::DATA_W-1:0] search_key,
    output      logic signed [ilis_pkg::DATA_W-1:0] value,
    output      logic                               match
);
    import ilis_pkg::*;

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     match_reg;
    logic                     match_next;

    always_comb
    begin
        unique case (ctrl.sel)
            CELL_LEFT:  value_next = left_value;
            CELL_RIGHT: value_next = right_value;
            CELL_NEW:   value_next = new_value;
            CELL_HEAD:  value_next = head_value;
            default:    value_next = value_reg;
        endcase
    end

    assign match_next = ctrl.cmp_en && (value_reg == search_key);

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        match_reg <= match_next;
    end

    assign value = value_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

[tb/list_mirror_pkg.sv]
package list_mirror_pkg;

    import ilis_pkg::*;

    // mirror of the list contents plus the responses still owed by the block
    class list_mirror;
        logic signed [DATA_W-1:0] cells [CAPACITY];
        int                       used     = 0;
        rsp_item_t                pending_rsp [$];
        int                       failures = 0;

        // update the mirror for an accepted request and queue what it should answer
        function void note_request(req_item_t r);
            rsp_item_t e;
            int        i;
            int        p;
            e      = '0;
            e.last = 1'b1;
            p      = int'(r.position);
            case (r.req_type)
                REQ_INSERT:
                begin
                    if (p <= used && used < CAPACITY)
                    begin
                        for (i = used; i > p; i--)
                            cells[i] = cells[i-1];
                        cells[p] = r.value_in;
                        used++;
                        e.ok = 1'b1;
                    end
                    pending_rsp.push_back(e);
                end
                REQ_ERASE:
                begin
                    if (p < used)
                    begin
                        for (i = p + 1; i < used; i++)
                            cells[i-1] = cells[i];
                        used--;
                        e.ok = 1'b1;
                    end
                    pending_rsp.push_back(e);
                end
                REQ_SEARCH:
                begin
                    for (i = 0; i < used; i++)
                        if (cells[i] == r.value_in)
                            e.ok = 1'b1;
                    pending_rsp.push_back(e);
                end
                default:
                begin
                    e.ok = 1'b1;
                    if (used == 0)
                        pending_rsp.push_back(e);
                    for (i = 0; i < used; i++)
                    begin
                        e.is_item   = 1'b1;
                        e.value_out = cells[i];
                        e.last      = (i == used - 1);
                        pending_rsp.push_back(e);
                    end
                end
            endcase
        endfunction

        function void check_response(rsp_item_t got);
            rsp_item_t e;
            if (pending_rsp.size() == 0)
            begin
                $error("unexpected response: ok %0b is_item %0b value_out %0d last %0b",
                       got.ok, got.is_item, got.value_out, got.last);
                failures++;
                return;
            end
            e = pending_rsp.pop_front();
            if (got.ok !== e.ok)
            begin
                $error("ok: expected %0b, got %0b", e.ok, got.ok);
                failures++;
            end
            if (got.is_item !== e.is_item)
            begin
                $error("is_item: expected %0b, got %0b", e.is_item, got.is_item);
                failures++;
            end
            if (got.value_out !== e.value_out)
            begin
                $error("value_out: expected %0d, got %0d", e.value_out, got.value_out);
                failures++;
            end
            if (got.last !== e.last)
            begin
                $error("last: expected %0b, got %0b", e.last, got.last);
                failures++;
            end
        endfunction
    endclass

endpackage

[tb/tb_indexed_list_insert_erase_search.sv]
module tb_indexed_list_insert_erase_search;

    timeunit 1ns;
    timeprecision 1ps;

    import ilis_pkg::*;
    import list_mirror_pkg::*;

    localparam int CLK_PERIOD    = 12;
    // a full dump streams 32 responses, so leave room for a straggler
    localparam int SETTLE_CYCLES = 64;
    // long receiver hold-off, enough to back the block up into its request side
    localparam int HOLD_CYCLES   = 300;
    // timeout in ns, several times the slowest legal run
    localparam int TIMEOUT_NS    = 48_000_000;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_item_t rsp;

    list_mirror mirror = new;

    // main sequence asks, receiver answers once it is actually holding
    bit rsp_hold_pending = 1'b0;
    bit rsp_holding      = 1'b0;

    indexed_list_insert_erase_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // extremes, a narrow band around zero so duplicates appear, or anything at all
    function automatic logic signed [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return '0;
                default: return '1;
            endcase
        end
        if (roll < 4)
            return $signed($urandom_range(0, 16)) - 8;
        return $urandom;
    endfunction

    function automatic req_item_t mk_request(req_type_t t, int pos,
                                             logic signed [DATA_W-1:0] v);
        req_item_t r;
        r.req_type = t;
        r.position = POS_W'(pos);
        r.value_in = v;
        return r;
    endfunction

    // random request shaped by the mirror: mostly legal positions, some out of range
    function automatic req_item_t pick_request(int ins_pct, int era_pct);
        int  roll;
        bit  noise;
        int  pos;
        int  srch_pct;
        roll     = $urandom_range(0, 99);
        noise    = ($urandom_range(0, 9) == 0);
        srch_pct = (100 - ins_pct - era_pct) * 2 / 3;
        if (roll < ins_pct)
        begin
            if (noise)
                pos = $urandom_range(mirror.used + 1, 63);
            else
                pos = $urandom_range(0, mirror.used);
            return mk_request(REQ_INSERT, pos, pick_value());
        end
        if (roll < ins_pct + era_pct)
        begin
            if (noise || mirror.used == 0)
                pos = $urandom_range(mirror.used, 63);
            else
                pos = $urandom_range(0, mirror.used - 1);
            return mk_request(REQ_ERASE, pos, pick_value());
        end
        if (roll < ins_pct + era_pct + srch_pct)
        begin
            // look for a stored value more often than not
            if (mirror.used > 0 && $urandom_range(0, 9) < 6)
                return mk_request(REQ_SEARCH, $urandom_range(0, 63),
                                  mirror.cells[$urandom_range(0, mirror.used - 1)]);
            return mk_request(REQ_SEARCH, $urandom_range(0, 63), pick_value());
        end
        return mk_request(REQ_DUMP, $urandom_range(0, 63), pick_value());
    endfunction

    // valid stays high after acceptance, the next call either lowers it or
    // replaces the payload in the same step
    task automatic send_request(req_item_t r, int gap);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        mirror.note_request(r);
    endtask

    task automatic run_phase(int n, int ins_pct, int era_pct, bit burst);
        repeat (n)
            send_request(pick_request(ins_pct, era_pct), burst ? 0 : idle_gap());
    endtask

    // sender goes quiet until every owed response has come back
    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (mirror.pending_rsp.size() != 0);
    endtask

    // response side: ready runs of random length broken by random stalls,
    // plus one long hold-off on request from the main sequence
    initial
    begin
        int gap;
        forever
        begin
            if (rsp_hold_pending)
            begin
                rsp_ready <= 1'b0;
                rsp_holding = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_holding      = 1'b0;
                rsp_hold_pending = 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(40, 120)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                gap = idle_gap();
                if (gap > 0)
                begin
                    rsp_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // every accepted response is checked against the oldest owed one
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            mirror.check_response(rsp);
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list corner cases
        send_request(mk_request(REQ_DUMP,   0, '0), idle_gap());
        send_request(mk_request(REQ_ERASE,  0, '0), idle_gap());
        send_request(mk_request(REQ_SEARCH, 0, '0), idle_gap());
        send_request(mk_request(REQ_INSERT, 1, 32'h1234_5678), idle_gap());
        // build min, -1, max, 0 through head, tail and middle inserts
        send_request(mk_request(REQ_INSERT, 0, 32'h7FFF_FFFF), idle_gap());
        send_request(mk_request(REQ_INSERT, 0, 32'h8000_0000), idle_gap());
        send_request(mk_request(REQ_INSERT, 2, '0), idle_gap());
        send_request(mk_request(REQ_INSERT, 1, '1), idle_gap());
        send_request(mk_request(REQ_INSERT, 63, 32'h0000_0005), idle_gap());
        // search hits at head and tail, then a miss
        send_request(mk_request(REQ_SEARCH, 0, 32'h8000_0000), idle_gap());
        send_request(mk_request(REQ_SEARCH, 63, '0), idle_gap());
        send_request(mk_request(REQ_SEARCH, 0, 32'h0000_3039), idle_gap());
        send_request(mk_request(REQ_DUMP,   0, '0), idle_gap());
        // erase at count and far out of range, then middle, tail and head
        send_request(mk_request(REQ_ERASE,  4, '0), idle_gap());
        send_request(mk_request(REQ_ERASE,  63, '1), idle_gap());
        send_request(mk_request(REQ_ERASE,  1, '0), idle_gap());
        send_request(mk_request(REQ_ERASE,  2, '0), idle_gap());
        send_request(mk_request(REQ_ERASE,  0, '0), idle_gap());
        send_request(mk_request(REQ_SEARCH, 0, '1), idle_gap());
        send_request(mk_request(REQ_DUMP,   63, '1), idle_gap());
        send_request(mk_request(REQ_ERASE,  0, '0), idle_gap());
        send_request(mk_request(REQ_DUMP,   0, '0), idle_gap());

        // growth, mostly inserts
        run_phase(60, 60, 10, 1'b0);

        // sender pause until the block has answered everything
        wait_drained();

        // fill to capacity, then hammer the full list
        while (mirror.used < CAPACITY)
            send_request(mk_request(REQ_INSERT, $urandom_range(0, mirror.used), pick_value()),
                         idle_gap());
        repeat (6)
            send_request(mk_request(REQ_INSERT, $urandom_range(0, 63), pick_value()),
                         idle_gap());
        send_request(mk_request(REQ_DUMP, 0, '0), idle_gap());
        run_phase(20, 30, 30, 1'b0);

        // receiver holds off while the sender keeps offering back to back
        wait_drained();
        rsp_hold_pending = 1'b1;
        wait (rsp_holding);
        run_phase(30, 40, 30, 1'b1);

        // long mixed stretch, then a burst with no sender idling
        run_phase(150, 40, 35, 1'b0);
        run_phase(40, 45, 30, 1'b1);

        // drain to empty and poke the empty list again
        while (mirror.used > 0)
            send_request(mk_request(REQ_ERASE, $urandom_range(0, mirror.used - 1), pick_value()),
                         idle_gap());
        run_phase(10, 30, 30, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mirror.failures == 0 && mirror.pending_rsp.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
